@@ rtl/mlir_pkg.sv @@
package mlir_pkg;

    localparam int SampleW   = 16;
    localparam int BaseW     = 18;
    localparam int FillW     = 11;
    localparam int VolW      = 5;
    localparam int PhaseW    = 19;
    localparam int ProdW     = 27;
    localparam int MagW      = 9;
    localparam int MaxResults = 5;
    localparam int MulSteps  = 9;
    localparam int DivSteps  = 27;
    localparam int DigitCnt  = 4;

    localparam logic [BaseW-1:0]  BaseStepRst = 18'd79183;
    localparam logic [FillW-1:0]  FillRst     = 11'd1000;
    localparam logic [VolW-1:0]   VolRst      = 5'd1;
    localparam logic [PhaseW-1:0] PhaseOne    = 19'h10000;
    localparam logic [16:0]       TrimDivisor = 17'd50000;
    localparam logic signed [11:0] FillTarget = 12'sd1000;
    localparam logic signed [11:0] ErrLimit   = 12'sd500;

    localparam logic [1:0] RegBaseStep = 2'd0;
    localparam logic [1:0] RegFill     = 2'd1;
    localparam logic [1:0] RegVolShift = 2'd2;

    typedef struct packed {
        logic              ready;
        logic [PhaseW-1:0] step;
    } step_stat_t;

endpackage

@@ rtl/mlir_step_calc.sv @@
module mlir_step_calc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mlir_pkg::BaseW-1:0] base_step,
    input  logic [mlir_pkg::FillW-1:0] fill_permille,
    output mlir_pkg::step_stat_t       stat
);
    import mlir_pkg::*;

    typedef enum logic [3:0] {
        SC_LOAD = 4'b0001,
        SC_MUL  = 4'b0010,
        SC_DIV  = 4'b0100,
        SC_DONE = 4'b1000
    } sc_state_t;

    sc_state_t         state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [MagW-1:0]   mag_reg, mag_next;
    logic [ProdW-1:0]  mcand_reg, mcand_next;
    logic [ProdW-1:0]  acc_reg, acc_next;
    logic [15:0]       rem_reg, rem_next;
    logic [PhaseW-1:0] step_reg, step_next;

    logic signed [11:0] err;
    logic signed [11:0] err_clamped;
    logic [16:0]        trial;
    logic [PhaseW-1:0]  quot;

    always_comb
    begin
        err = $signed({1'b0, fill_permille}) - FillTarget;
        if (err > ErrLimit)
        begin
            err_clamped = ErrLimit;
        end
        else if (err < -ErrLimit)
        begin
            err_clamped = -ErrLimit;
        end
        else
        begin
            err_clamped = err;
        end
        trial = {rem_reg, acc_reg[ProdW-1]};
        quot  = acc_reg[PhaseW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        if (start)
        begin
            state_next = SC_LOAD;
        end
        else
        begin
            case (state_reg)
                SC_LOAD:
                begin
                    neg_next   = err_clamped[11];
                    mag_next   = err_clamped[11] ? MagW'(-err_clamped) : MagW'(err_clamped);
                    mcand_next = ProdW'(base_step);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = SC_MUL;
                end
                SC_MUL:
                begin
                    // shift-add, one multiplier bit per cycle
                    if (mag_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mag_next   = mag_reg >> 1;
                    mcand_next = mcand_reg << 1;
                    cnt_next   = cnt_reg + 5'd1;
                    if (cnt_reg == 5'(MulSteps - 1))
                    begin
                        cnt_next   = '0;
                        rem_next   = '0;
                        state_next = SC_DIV;
                    end
                end
                SC_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (trial >= TrimDivisor)
                    begin
                        rem_next = 16'(trial - TrimDivisor);
                        acc_next = {acc_reg[ProdW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[15:0];
                        acc_next = {acc_reg[ProdW-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DivSteps - 1))
                    begin
                        state_next = SC_DONE;
                    end
                end
                SC_DONE:
                begin
                    step_next = PhaseW'(base_step) + (neg_reg ? -quot : quot);
                end
                default:
                begin
                    state_next = SC_LOAD;
                end
            endcase
        end
    end

    logic ready_reg, ready_next;

    always_comb
    begin
        ready_next = ready_reg;
        if (start)
        begin
            ready_next = 1'b0;
        end
        else if (state_reg == SC_DIV && cnt_reg == 5'(DivSteps - 1))
        begin
            ready_next = 1'b0;
        end
        else if (state_reg == SC_DONE)
        begin
            ready_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_LOAD;
            cnt_reg   <= '0;
            ready_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
    end

    assign stat.ready = ready_reg && (state_reg == SC_DONE) && !start;
    assign stat.step  = step_reg;

endmodule

@@ rtl/mix_linear_interp_resampler.sv @@
// channel   | handshake                   | payload
// ----------+-----------------------------+-------------------------------
// sample    | sample_valid / sample_stall | first_sample, second_sample
// result    | result_valid / result_stall | out_sample, last_of_run
// config    | apb psel/penable/pwrite     | paddr[3:2] index, pwdata
//
// an input transfer is taken in idle, then each result runs one check, four 4-bit
// multiply digits and one load, and a final check returns to idle, the only state that takes a sample
// the 4-bit digit-serial interpolation multiplier takes most of the steps of each result
// after reset and after each write to base_step or fill_permille the step unit
// runs its 9 multiply bits and 27 divide bits with sample_stall high
// a held result_stall stops result loads, and no sample is taken while a load waits
module mix_linear_interp_resampler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic signed [mlir_pkg::SampleW-1:0] first_sample,
    input  logic signed [mlir_pkg::SampleW-1:0] second_sample,
    output logic        result_valid,
    input  logic        result_stall,
    output logic signed [mlir_pkg::SampleW-1:0] out_sample,
    output logic        last_of_run
);
    import mlir_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    logic [BaseW-1:0] base_reg;
    logic [FillW-1:0] fill_reg;
    logic [VolW-1:0]  vol_reg;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;
    step_stat_t       stat;

    state_t                     state_reg, state_next;
    logic [2:0]                 count_reg, count_next;
    logic [PhaseW-1:0]          phase_reg, phase_next;
    logic signed [SampleW-1:0]  prev_reg, prev_next;
    logic signed [SampleW-1:0]  mixed_reg, mixed_next;
    logic signed [16:0]         d_reg, d_next;
    logic [15:0]                ph_sh_reg, ph_sh_next;
    logic signed [32:0]         acc_reg, acc_next;
    logic [1:0]                 dig_reg, dig_next;
    logic                       rv_reg, rv_next;
    logic signed [SampleW-1:0]  rs_reg, rs_next;
    logic                       rl_reg, rl_next;

    logic signed [16:0] sum;
    logic signed [16:0] shifted;
    logic signed [SampleW-1:0] mix;
    logic signed [21:0] pp;
    logic signed [16:0] interp;
    logic [PhaseW-1:0]  phase_adv;
    logic               accept;
    logic               out_free;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            RegBaseStep: prdata = 32'(base_reg);
            RegFill:     prdata = 32'(fill_reg);
            RegVolShift: prdata = 32'(vol_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BaseStepRst;
            fill_reg <= FillRst;
            vol_reg  <= VolRst;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                RegBaseStep: base_reg <= pwdata[BaseW-1:0];
                RegFill:     fill_reg <= pwdata[FillW-1:0];
                RegVolShift: vol_reg  <= pwdata[VolW-1:0];
                default:     ;
            endcase
        end
    end

    mlir_step_calc u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (cfg_wr && (cfg_idx == RegBaseStep || cfg_idx == RegFill)),
        .base_step     (base_reg),
        .fill_permille (fill_reg),
        .stat          (stat)
    );

    // mixing: add, arithmetic shift, saturate
    always_comb
    begin
        sum     = {first_sample[SampleW-1], first_sample}
                + {second_sample[SampleW-1], second_sample};
        shifted = sum >>> vol_reg;
        if (shifted[16] != shifted[15])
        begin
            mix = shifted[16] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            mix = shifted[15:0];
        end
    end

    assign sample_stall = !(state_reg == ST_IDLE && stat.ready) || cfg_wr;
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !rv_reg || !result_stall;
    assign pp           = d_reg * $signed({1'b0, ph_sh_reg[15:12]});
    assign interp       = {prev_reg[SampleW-1], prev_reg} + acc_reg[32:16];
    assign phase_adv    = phase_reg + stat.step;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        prev_next  = prev_reg;
        mixed_next = mixed_reg;
        d_next     = d_reg;
        ph_sh_next = ph_sh_reg;
        acc_next   = acc_reg;
        dig_next   = dig_reg;
        rs_next    = rs_reg;
        rl_next    = rl_reg;
        rv_next    = rv_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mixed_next = mix;
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (phase_reg[PhaseW-1:16] == '0 && count_reg < 3'(MaxResults))
                begin
                    d_next     = {mixed_reg[SampleW-1], mixed_reg}
                               - {prev_reg[SampleW-1], prev_reg};
                    ph_sh_next = phase_reg[15:0];
                    acc_next   = '0;
                    dig_next   = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    // run done, or capped with phase still below one
                    phase_next = (phase_reg[PhaseW-1:16] != '0) ? phase_reg - PhaseOne : '0;
                    prev_next  = mixed_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                acc_next   = {acc_reg[28:0], 4'b0000} + {{11{pp[21]}}, pp};
                ph_sh_next = {ph_sh_reg[11:0], 4'b0000};
                dig_next   = dig_reg + 2'd1;
                if (dig_reg == 2'(DigitCnt - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    rv_next    = 1'b1;
                    rs_next    = interp[15:0];
                    rl_next    = (phase_adv[PhaseW-1:16] != '0)
                              || (count_reg == 3'(MaxResults - 1));
                    phase_next = phase_adv;
                    count_next = count_reg + 3'd1;
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            phase_reg <= '0;
            prev_reg  <= '0;
            dig_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            dig_reg   <= dig_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mixed_reg <= mixed_next;
        d_reg     <= d_next;
        ph_sh_reg <= ph_sh_next;
        acc_reg   <= acc_next;
        rs_reg    <= rs_next;
        rl_reg    <= rl_next;
    end

    assign result_valid = rv_reg;
    assign out_sample   = rs_reg;
    assign last_of_run  = rl_reg;

    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> phase_reg[PhaseW-1:16] == '0)
        else $error("result computed with phase at or above one");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(MaxResults))
        else $error("result count above cap");

    a_accept_ready: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> stat.ready)
        else $error("sample taken before step is ready");

    a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL && dig_reg == 2'(DigitCnt - 1) |=> state_reg == ST_EMIT)
        else $error("multiply did not finish after four digits");

endmodule

@@ sim/tb_mix_linear_interp_resampler.sv @@
`timescale 1ns / 100ps

module tb_mix_linear_interp_resampler;
    import mlir_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 48;
    localparam logic [1:0] RegUnused = 2'd3;

    typedef struct {
        logic signed [SampleW-1:0] first;
        logic signed [SampleW-1:0] second;
    } sample_pair_t;

    typedef struct {
        logic signed [SampleW-1:0] sample;
        logic                      last;
    } interp_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    logic signed [SampleW-1:0] first_sample = '0;
    logic signed [SampleW-1:0] second_sample = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic signed [SampleW-1:0] out_sample;
    logic        last_of_run;

    sample_pair_t pending_pairs[$];
    interp_out_t  awaited_samples[$];
    sample_pair_t drive_pair;
    interp_out_t  head_out;

    logic [BaseW-1:0]          cfg_base = BaseStepRst;
    logic [FillW-1:0]          cfg_fill = FillRst;
    logic [VolW-1:0]           cfg_vol = VolRst;
    logic [PhaseW-1:0]         phase_acc = '0;
    logic signed [SampleW-1:0] prev_mixed = '0;

    int idle_pct = 7;
    int error_count = 0;
    int cycle_count = 0;

    mix_linear_interp_resampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .first_sample (first_sample),
        .second_sample(second_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_sample   (out_sample),
        .last_of_run  (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic logic signed [SampleW-1:0] clamp_to_sample(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[SampleW-1:0];
    endfunction

    function automatic logic [PhaseW-1:0] trimmed_step();
        longint err;
        longint trim;
        err = longint'(cfg_fill) - longint'(FillTarget);
        if (err > longint'(ErrLimit))
            err = longint'(ErrLimit);
        if (err < -longint'(ErrLimit))
            err = -longint'(ErrLimit);
        trim = (longint'(cfg_base) * err) / longint'(TrimDivisor);
        return PhaseW'(longint'(cfg_base) + trim);
    endfunction

    function automatic void interpolate_pair(input logic signed [SampleW-1:0] a,
                                             input logic signed [SampleW-1:0] b);
        longint            mixed;
        longint            diff;
        logic [PhaseW-1:0] step;
        interp_out_t       run[MaxResults];
        int                n;
        mixed = clamp_to_sample((longint'(a) + longint'(b)) >>> cfg_vol);
        step = trimmed_step();
        n = 0;
        while (phase_acc < PhaseOne && n < MaxResults) begin
            diff = mixed - longint'(prev_mixed);
            run[n].sample = clamp_to_sample(longint'(prev_mixed)
                                            + ((diff * longint'(phase_acc)) >>> 16));
            run[n].last = 1'b0;
            n++;
            phase_acc = phase_acc + step;
        end
        if (n > 0)
            run[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            awaited_samples.push_back(run[i]);
        if (phase_acc >= PhaseOne)
            phase_acc = phase_acc - PhaseOne;
        else
            phase_acc = '0;
        prev_mixed = mixed[SampleW-1:0];
    endfunction

    function automatic logic signed [SampleW-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            return (pick % 2) ? 16'sh7FFF : 16'sh8000;
        if (pick < 35)
            return SampleW'($urandom_range(600)) - 16'sd300;
        return SampleW'($urandom());
    endfunction

    task automatic queue_pair(input logic signed [SampleW-1:0] a,
                              input logic signed [SampleW-1:0] b);
        sample_pair_t p;
        p.first = a;
        p.second = b;
        pending_pairs.push_back(p);
    endtask

    task automatic queue_random(input int count);
        @(negedge clk);
        repeat (count)
            queue_pair(random_sample(), random_sample());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegBaseStep: cfg_base = value[BaseW-1:0];
            RegFill:     cfg_fill = value[FillW-1:0];
            RegVolShift: cfg_vol = value[VolW-1:0];
            default:     ;
        endcase
    endtask

    task automatic set_mode(input logic [BaseW-1:0] base, input logic [FillW-1:0] fill,
                            input logic [VolW-1:0] vol);
        write_reg(RegBaseStep, 32'(base));
        write_reg(RegFill, 32'(fill));
        write_reg(RegVolShift, 32'(vol));
    endtask

    // wait until every transfer is in and every result is out, then let the block settle
    task automatic drain();
        do
            @(negedge clk);
        while (pending_pairs.size() != 0 || sample_valid || awaited_samples.size() != 0);
        repeat (DrainCycles) @(negedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && (!sample_valid || !sample_stall)) begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                drive_pair = pending_pairs.pop_front();
                sample_valid <= 1'b1;
                first_sample <= drive_pair.first;
                second_sample <= drive_pair.second;
            end else begin
                sample_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        result_stall <= rst_n && ($urandom_range(99) < idle_pct);

    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                if (awaited_samples.size() == 0) begin
                    $error("unexpected result: out_sample %0d last_of_run %0b",
                           out_sample, last_of_run);
                    error_count++;
                end else begin
                    head_out = awaited_samples.pop_front();
                    if (out_sample !== head_out.sample) begin
                        $error("out_sample mismatch: expected %0d, got %0d",
                               head_out.sample, out_sample);
                        error_count++;
                    end
                    if (last_of_run !== head_out.last) begin
                        $error("last_of_run mismatch: expected %0b, got %0b",
                               head_out.last, last_of_run);
                        error_count++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
                interpolate_pair(first_sample, second_sample);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: full-scale sums, sign mix, inputs with no output
        @(negedge clk);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh7FFF, 16'sh8000);
        queue_pair(16'sh8000, 16'sh7FFF);
        queue_pair(16'sd0, 16'sd0);
        queue_pair(-16'sd1, -16'sd1);
        queue_pair(16'sd1, 16'sd0);
        queue_pair(-16'sd1, 16'sd0);
        queue_pair(16'sh4000, 16'sh4000);
        queue_pair(16'shAAAA, 16'sh5555);
        drain();

        // small step, fill beyond the clamp, no shift
        set_mode(18'd16384, 11'd2000, 5'd0);
        @(negedge clk);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh7FFF, 16'sd1);
        queue_pair(16'sh8000, -16'sd1);
        drain();

        // zero step hits the run cap; shift of 31
        set_mode(18'd0, 11'd1000, 5'd31);
        @(negedge clk);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh1234, 16'sh0001);
        drain();

        // tiny step, fill at clamp edge, shift of 16
        set_mode(18'd3, 11'd1500, 5'd16);
        write_reg(RegUnused, 32'hFFFF_FFFF);
        @(negedge clk);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        drain();

        // largest step with fill beyond its range
        set_mode(18'd262143, 11'd2047, 5'd2);
        @(negedge clk);
        queue_pair(16'sh7FFF, 16'sh8000);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        drain();

        // one output per transfer, no idling on either side
        idle_pct = 0;
        set_mode(18'd65536, 11'd1000, 5'd1);
        queue_random(60);
        drain();
        idle_pct = 7;

        // largest step, empty queue: outputs are rare
        set_mode(18'd262143, 11'd0, 5'd0);
        queue_random(40);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            set_mode(($urandom_range(9) == 0) ? BaseW'($urandom_range(16383))
                                              : BaseW'($urandom_range(262143, 16384)),
                     FillW'($urandom_range(2047)),
                     ($urandom_range(4) == 0) ? VolW'($urandom_range(31, 17))
                                              : VolW'($urandom_range(16)));
            queue_random(42);
            drain();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
